### rtl/can_fd_frame_bit_decoder_unit_assert.svh
// assertion macros for the can fd frame bit decoder
// used by the decoder core and the top level, no other dependencies
`ifndef CAN_FD_FRAME_BIT_DECODER_UNIT_ASSERT_SVH
`define CAN_FD_FRAME_BIT_DECODER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CFD_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define CFD_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/cfd_pkg.sv
// package for the can fd frame bit decoder
// types, phase codes, event codes and the fd length table; no dependencies
package cfd_pkg;

  typedef enum logic [4:0] {
    PH_SOF, PH_ID1, PH_RR12, PH_IDE, PH_ID2, PH_RR32, PH_R0, PH_R1, PH_R1EXT,
    PH_BRS, PH_ESI, PH_DLC, PH_DATA, PH_FSB, PH_CRC15, PH_SBC, PH_CRC17,
    PH_CRC21, PH_CRCDEL, PH_ACK, PH_ACKDEL, PH_EOF
  } phase_t;

  localparam logic [4:0] EV_SOF = 5'd0, EV_ID = 5'd1, EV_ID_WARN = 5'd2, EV_RTR = 5'd3,
    EV_SRR = 5'd4, EV_IDE = 5'd5, EV_RES_FLEX = 5'd6, EV_RES = 5'd7, EV_BRS = 5'd8,
    EV_ESI = 5'd9, EV_DLC = 5'd10, EV_DATA = 5'd11, EV_EXT_ID = 5'd12,
    EV_FULL_ID = 5'd13, EV_FSB = 5'd14, EV_STUFF_CNT = 5'd15, EV_CRC15 = 5'd16,
    EV_CRC17 = 5'd17, EV_CRC21 = 5'd18, EV_FD_CRC_RAW = 5'd19, EV_CRC_DELIM = 5'd20,
    EV_CRC_DELIM_WARN = 5'd21, EV_ACK = 5'd22, EV_ACK_DELIM = 5'd23,
    EV_ACK_DELIM_WARN = 5'd24, EV_EOF = 5'd25, EV_EOF_ERR = 5'd26, EV_STUFF = 5'd27,
    EV_STUFF_ERR = 5'd28;

  localparam logic [1:0] ACT_NONE = 2'd0, ACT_RESYNC = 2'd1, ACT_IDLE = 2'd2;

  typedef struct packed {
    logic [4:0]  code;
    logic [31:0] value;
    logic [5:0]  count;
    logic [31:0] start;
    logic [31:0] dur;
  } event_t;

  // results of one bit, up to three, with the common sampler fields
  typedef struct packed {
    logic [1:0] n;
    event_t     ev0;
    event_t     ev1;
    event_t     ev2;
    logic       rate_fast;
    logic [1:0] action;
  } bit_result_t;

  function automatic logic [6:0] fd_len(input logic [3:0] c);
    logic [6:0] r;
    case (c)
      4'd9:    r = 7'd12;
      4'd10:   r = 7'd16;
      4'd11:   r = 7'd20;
      4'd12:   r = 7'd24;
      4'd13:   r = 7'd32;
      4'd14:   r = 7'd48;
      4'd15:   r = 7'd64;
      default: r = {3'd0, c};
    endcase
    return r;
  endfunction

endpackage

### rtl/can_fd_frame_bit_decoder_unit.sv
// can fd frame bit decoder: usage
// slave stream s_axis_*: one sampled bus bit per transaction, tdata holds
//   bit_value [0], bit_start [32:1], bit_end [64:33], zero filled to 72 bits
// master stream m_axis_*: one annotated field event per transaction;
//   tlast marks the last event caused by an input bit
// an input bit is decoded in the cycle it is accepted and its zero to
//   three events are registered; the first appears on the next cycle
// throughput: a bit giving k events holds the output register until all
//   k are taken; the next bit is taken while the last event of the previous
//   one is being taken, so one bit per cycle when events are sparse and m_axis_tready stays high
// recessive idle bits before start of frame are taken but give no event at all
// rst (synchronous) returns the decoder to start of frame and drops
//   pending events; a stall on m_axis_tready holds the current event and
//   back-pressures s_axis_tready
`include "can_fd_frame_bit_decoder_unit_assert.svh"
module can_fd_frame_bit_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // bit_value, bit_start, bit_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // event_code, field_value, bit_count, start_sample, duration_samples
  output logic [111:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // rate_fast, sampler_action
  output logic        m_axis_tlast
);

  cfd_pkg::bit_result_t res;
  cfd_pkg::event_t      ev;
  logic busy, take, rate_fast;
  logic [1:0] action;

  // a bit is taken whenever the output holds nothing, or only a final beat being taken
  assign s_axis_tready = !busy;
  assign take = s_axis_tvalid && s_axis_tready;

  cfd_core u_core (
    .clk(clk), .rst(rst), .bit_ok(take),
    .bit_value(s_axis_tdata[0]), .bit_start(s_axis_tdata[32:1]),
    .bit_end(s_axis_tdata[64:33]), .result(res)
  );

  cfd_out u_out (
    .clk(clk), .rst(rst), .load(take), .res_in(res), .busy(busy),
    .tready(m_axis_tready), .tvalid(m_axis_tvalid), .ev(ev),
    .rate_fast(rate_fast), .action(action), .last(m_axis_tlast)
  );

  // packed from the lowest bit up, zero filled to whole bytes
  assign m_axis_tdata = {5'd0, ev.dur, ev.start, ev.count, ev.value, ev.code};
  assign m_axis_tuser = {action, rate_fast};

  `CFD_ASSERT_IMP(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)
  `CFD_ASSERT_NEXT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `CFD_ASSERT_IMP(a_action_code, clk, rst, m_axis_tvalid, m_axis_tuser[2:1] != 2'd3)

endmodule

### rtl/cfd_core.sv
// decoder core: registered frame state and the combinational per-bit decode
// depends on cfd_pkg and the assertion header
`include "can_fd_frame_bit_decoder_unit_assert.svh"
module cfd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  bit_ok,
  input  logic                  bit_value,
  input  logic [31:0]           bit_start,
  input  logic [31:0]           bit_end,
  output cfd_pkg::bit_result_t  result
);

  cfd_pkg::phase_t phase, phase_next;
  logic [1:0]  ext_kind, ext_kind_next;
  logic        flex, flex_next;
  logic [10:0] base_id, base_id_next;
  logic [17:0] shift, shift_next;
  logic [4:0]  fcnt, fcnt_next;
  logic [3:0]  scnt, scnt_next;
  logic [4:0]  hist, hist_next;
  logic [2:0]  hcnt, hcnt_next;
  logic [6:0]  dlen, dlen_next;
  logic [6:0]  bytes, bytes_next;
  logic [20:0] crc, crc_next;
  logic [31:0] raw, raw_next;
  logic [5:0]  raw_bits, raw_bits_next;
  logic [31:0] raw_start, raw_start_next;
  logic [31:0] fstart, fstart_next;
  logic        held_v, held_v_next;
  logic [31:0] held_s, held_s_next, held_e, held_e_next;
  logic        remote, remote_next;
  logic        fast, fast_next;

  always_comb begin
    cfd_pkg::event_t evs [3];
    logic [1:0]  n;
    logic [1:0]  act;
    logic [31:0] d;
    logic        stuff_on, clr;
    logic [4:0]  fb;
    logic [17:0] fs;
    logic [31:0] fst;
    logic [3:0]  fsc;
    logic [20:0] fcrc;
    logic [5:0]  fcount;
    logic [3:0]  c;
    logic [6:0]  len;
    logic        fixed_pos;
    phase_next = phase; ext_kind_next = ext_kind; flex_next = flex;
    base_id_next = base_id; shift_next = shift; fcnt_next = fcnt; scnt_next = scnt;
    hist_next = hist; hcnt_next = hcnt; dlen_next = dlen; bytes_next = bytes;
    crc_next = crc; raw_next = raw; raw_bits_next = raw_bits;
    raw_start_next = raw_start; fstart_next = fstart; held_v_next = held_v;
    held_s_next = held_s; held_e_next = held_e; remote_next = remote;
    fast_next = fast;
    for (int i = 0; i < 3; i++) evs[i] = '0;
    n = 2'd0; act = cfd_pkg::ACT_NONE; clr = 1'b0;
    d = bit_end - bit_start;
    // field helper: value of the open field after this bit
    fst = (fcnt == 5'd0) ? bit_start : fstart;
    fsc = (fcnt == 5'd0) ? 4'd0 : scnt;
    fcrc = (fcnt == 5'd0) ? 21'd0 : crc;
    fs = {shift[16:0], bit_value};
    fb = fcnt + 5'd1;
    fcount = {1'b0, fb} + {2'b0, fsc};
    c = fs[3:0];
    len = 7'd0;
    fixed_pos = 1'b0;
    stuff_on = !(phase == cfd_pkg::PH_SOF || phase == cfd_pkg::PH_ACK ||
                 phase == cfd_pkg::PH_ACKDEL || phase == cfd_pkg::PH_EOF) &&
               !(flex && (phase == cfd_pkg::PH_FSB || phase == cfd_pkg::PH_SBC ||
                 phase == cfd_pkg::PH_CRC17 || phase == cfd_pkg::PH_CRC21 ||
                 phase == cfd_pkg::PH_CRCDEL));
    if (!bit_ok || (phase == cfd_pkg::PH_SOF && bit_value)) begin
      n = 2'd0;
    end else if (stuff_on && hcnt >= 3'd5 && (hist == 5'd0 || hist == 5'h1F)) begin
      if ((hist == 5'd0) ? !bit_value : bit_value) begin
        evs[0] = '{cfd_pkg::EV_STUFF_ERR, 32'd0, 6'd1, bit_start, d};
        n = 2'd1; clr = 1'b1; act = cfd_pkg::ACT_IDLE;
      end else begin
        evs[0] = '{cfd_pkg::EV_STUFF, 32'd0, 6'd1, bit_start, d};
        n = 2'd1;
        if (scnt < 4'd15) scnt_next = scnt + 4'd1;
        hist_next = {hist[3:0], bit_value};
      end
    end else begin
      hist_next = {hist[3:0], bit_value};
      if (hcnt < 3'd5) hcnt_next = hcnt + 3'd1;
      unique case (phase)
        cfd_pkg::PH_SOF: begin
          evs[0] = '{cfd_pkg::EV_SOF, 32'd0, 6'd1, bit_start, d};
          n = 2'd1; phase_next = cfd_pkg::PH_ID1;
        end
        cfd_pkg::PH_ID1, cfd_pkg::PH_ID2, cfd_pkg::PH_DLC, cfd_pkg::PH_DATA,
        cfd_pkg::PH_CRC15, cfd_pkg::PH_SBC, cfd_pkg::PH_CRC17, cfd_pkg::PH_CRC21,
        cfd_pkg::PH_EOF: begin
          fstart_next = fst; scnt_next = fsc; crc_next = fcrc;
          shift_next = fs; fcnt_next = fb;
          case (phase)
            cfd_pkg::PH_ID1: if (fb >= 5'd11) begin
              base_id_next = fs[10:0];
              evs[0] = '{cfd_pkg::EV_ID, {21'd0, fs[10:0]}, fcount, fst, bit_end - fst};
              evs[1] = '{cfd_pkg::EV_ID_WARN, {21'd0, fs[10:0]}, fcount, fst,
                         bit_end - fst};
              n = (fs[10:4] == 7'h7F) ? 2'd2 : 2'd1;
              fcnt_next = 5'd0; phase_next = cfd_pkg::PH_RR12;
            end
            cfd_pkg::PH_ID2: if (fb >= 5'd18) begin
              evs[0] = '{cfd_pkg::EV_EXT_ID, {14'd0, fs}, fcount, fst, bit_end - fst};
              evs[1] = '{cfd_pkg::EV_FULL_ID, {3'd0, base_id, fs}, fcount, fst,
                         bit_end - fst};
              n = 2'd2; fcnt_next = 5'd0; phase_next = cfd_pkg::PH_RR32;
            end
            cfd_pkg::PH_DLC: if (fb >= 5'd4) begin
              if (flex) len = cfd_pkg::fd_len(c);
              else len = remote ? 7'd0 : ((c > 4'd8) ? 7'd8 : {3'd0, c});
              dlen_next = len;
              evs[0] = '{cfd_pkg::EV_DLC, flex ? {25'd0, len} : {28'd0, c}, fcount, fst,
                         bit_end - fst};
              n = 2'd1; fcnt_next = 5'd0; bytes_next = 7'd0;
              raw_next = 32'd0; raw_bits_next = 6'd0;
              phase_next = (len != 7'd0) ? cfd_pkg::PH_DATA :
                           (flex ? cfd_pkg::PH_FSB : cfd_pkg::PH_CRC15);
            end
            cfd_pkg::PH_DATA: if (fb >= 5'd8) begin
              evs[0] = '{cfd_pkg::EV_DATA, {24'd0, fs[7:0]}, fcount, fst, bit_end - fst};
              n = 2'd1; fcnt_next = 5'd0; bytes_next = bytes + 7'd1;
              if (bytes + 7'd1 >= dlen) begin
                raw_next = 32'd0; raw_bits_next = 6'd0;
                phase_next = flex ? cfd_pkg::PH_FSB : cfd_pkg::PH_CRC15;
              end
            end
            cfd_pkg::PH_CRC15: if (fb >= 5'd15) begin
              crc_next = {6'd0, fs[14:0]};
              evs[0] = '{cfd_pkg::EV_CRC15, {17'd0, fs[14:0]}, fcount, fst,
                         bit_end - fst};
              n = 2'd1; fcnt_next = 5'd0; phase_next = cfd_pkg::PH_CRCDEL;
            end
            cfd_pkg::PH_SBC: begin
              raw_next = {raw[30:0], bit_value}; raw_bits_next = raw_bits + 6'd1;
              if (fb >= 5'd4) begin
                evs[0] = '{cfd_pkg::EV_STUFF_CNT, {28'd0, c}, fcount, fst,
                           bit_end - fst};
                n = 2'd1; fcnt_next = 5'd0;
                phase_next = (dlen <= 7'd16) ? cfd_pkg::PH_CRC17 : cfd_pkg::PH_CRC21;
              end
            end
            cfd_pkg::PH_CRC17, cfd_pkg::PH_CRC21: begin
              raw_next = {raw[30:0], bit_value}; raw_bits_next = raw_bits + 6'd1;
              // fixed stuff bit every fifth position, starting with the first
              fixed_pos = (fb == 5'd1) || (fb == 5'd6) || (fb == 5'd11) ||
                          (fb == 5'd16) || (fb == 5'd21) || (fb == 5'd26);
              if (fixed_pos) begin
                evs[0] = '{cfd_pkg::EV_FSB, {31'd0, bit_value}, 6'd1, bit_start, d};
                n = 2'd1;
              end else begin
                crc_next = {fcrc[19:0], bit_value};
              end
              if (fb >= ((phase == cfd_pkg::PH_CRC17) ? 5'd22 : 5'd27)) begin
                evs[n] = '{(phase == cfd_pkg::PH_CRC17) ? cfd_pkg::EV_CRC17 :
                           cfd_pkg::EV_CRC21, {11'd0, crc_next}, fcount, fst,
                           bit_end - fst};
                evs[n + 2'd1] = '{cfd_pkg::EV_FD_CRC_RAW, raw_next, raw_bits_next,
                                  raw_start, bit_end - raw_start};
                n = n + 2'd2; fcnt_next = 5'd0; phase_next = cfd_pkg::PH_CRCDEL;
              end
            end
            default: if (fb >= 5'd7) begin
              evs[0] = '{cfd_pkg::EV_EOF, {25'd0, fs[6:0]}, 6'd7, fst, bit_end - fst};
              evs[1] = '{cfd_pkg::EV_EOF_ERR, {25'd0, fs[6:0]}, 6'd1, bit_start, d};
              n = (fs[6:0] != 7'h7F) ? 2'd2 : 2'd1;
              clr = 1'b1; act = cfd_pkg::ACT_IDLE;
            end
          endcase
        end
        cfd_pkg::PH_RR12: begin
          held_v_next = bit_value; held_s_next = bit_start; held_e_next = bit_end;
          phase_next = cfd_pkg::PH_IDE;
        end
        cfd_pkg::PH_IDE: begin
          ext_kind_next = bit_value ? 2'd2 : 2'd1;
          evs[0] = '{cfd_pkg::EV_IDE, {31'd0, bit_value}, 6'd1, bit_start, d};
          n = 2'd1;
          phase_next = bit_value ? cfd_pkg::PH_ID2 : cfd_pkg::PH_R0;
        end
        cfd_pkg::PH_RR32: begin
          evs[0] = '{cfd_pkg::EV_RTR, {31'd0, bit_value}, 6'd1, bit_start, d};
          n = 2'd1; remote_next = bit_value; phase_next = cfd_pkg::PH_R0;
        end
        cfd_pkg::PH_R0: begin
          flex_next = bit_value;
          if (ext_kind == 2'd2 || bit_value) begin
            evs[0] = '{cfd_pkg::EV_RES_FLEX, 32'd1, 6'd1, bit_start, d};
            evs[1] = '{cfd_pkg::EV_SRR, {31'd0, held_v}, 6'd1, held_s, held_e - held_s};
            evs[2] = '{cfd_pkg::EV_RES, {31'd0, bit_value}, 6'd1, bit_start, d};
            if (!bit_value) begin
              evs[0] = evs[1]; evs[1] = evs[2]; n = 2'd2;
            end else begin
              n = 2'd3;
            end
            phase_next = bit_value ? cfd_pkg::PH_R1 : cfd_pkg::PH_R1EXT;
          end else begin
            evs[0] = '{cfd_pkg::EV_RTR, {31'd0, held_v}, 6'd1, held_s, held_e - held_s};
            evs[1] = '{cfd_pkg::EV_RES, 32'd0, 6'd1, bit_start, d};
            n = 2'd2; remote_next = held_v; phase_next = cfd_pkg::PH_DLC;
          end
        end
        cfd_pkg::PH_R1EXT: begin
          evs[0] = '{cfd_pkg::EV_RES, {31'd0, bit_value}, 6'd1, bit_start, d};
          n = 2'd1; phase_next = cfd_pkg::PH_DLC;
        end
        cfd_pkg::PH_R1: begin
          evs[0] = '{cfd_pkg::EV_RES, {31'd0, bit_value}, 6'd1, bit_start, d};
          n = 2'd1; phase_next = cfd_pkg::PH_BRS; act = cfd_pkg::ACT_RESYNC;
        end
        cfd_pkg::PH_BRS: begin
          evs[0] = '{cfd_pkg::EV_BRS, {31'd0, bit_value}, 6'd1, bit_start, d};
          n = 2'd1; if (bit_value) fast_next = 1'b1; phase_next = cfd_pkg::PH_ESI;
        end
        cfd_pkg::PH_ESI: begin
          evs[0] = '{cfd_pkg::EV_ESI, {31'd0, bit_value}, 6'd1, bit_start, d};
          n = 2'd1; phase_next = cfd_pkg::PH_DLC;
        end
        cfd_pkg::PH_FSB: begin
          evs[0] = '{cfd_pkg::EV_FSB, {31'd0, bit_value}, 6'd1, bit_start, d};
          n = 2'd1; raw_next = {31'd0, bit_value}; raw_bits_next = 6'd1;
          raw_start_next = bit_start; phase_next = cfd_pkg::PH_SBC;
        end
        cfd_pkg::PH_CRCDEL: begin
          evs[0] = '{cfd_pkg::EV_CRC_DELIM, {31'd0, bit_value}, 6'd1, bit_start, d};
          evs[1] = '{cfd_pkg::EV_CRC_DELIM_WARN, 32'd0, 6'd1, bit_start, d};
          n = bit_value ? 2'd1 : 2'd2;
          if (flex) fast_next = 1'b0;
          phase_next = cfd_pkg::PH_ACK;
        end
        cfd_pkg::PH_ACK: begin
          evs[0] = '{cfd_pkg::EV_ACK, {31'd0, bit_value}, 6'd1, bit_start, d};
          n = 2'd1; phase_next = cfd_pkg::PH_ACKDEL;
        end
        cfd_pkg::PH_ACKDEL: begin
          evs[0] = '{cfd_pkg::EV_ACK_DELIM, {31'd0, bit_value}, 6'd1, bit_start, d};
          evs[1] = '{cfd_pkg::EV_ACK_DELIM_WARN, 32'd0, 6'd1, bit_start, d};
          n = bit_value ? 2'd1 : 2'd2; phase_next = cfd_pkg::PH_EOF;
        end
        default: clr = 1'b1;
      endcase
    end
    if (clr) begin
      phase_next = cfd_pkg::PH_SOF; ext_kind_next = 2'd0; flex_next = 1'b0;
      base_id_next = '0; shift_next = '0; fcnt_next = '0; scnt_next = '0;
      hist_next = '0; hcnt_next = '0; dlen_next = '0; bytes_next = '0;
      crc_next = '0; raw_next = '0; raw_bits_next = '0; raw_start_next = '0;
      fstart_next = '0; held_v_next = 1'b0; held_s_next = '0; held_e_next = '0;
      remote_next = 1'b0; fast_next = 1'b0;
    end
    result.n = n; result.ev0 = evs[0]; result.ev1 = evs[1]; result.ev2 = evs[2];
    result.rate_fast = fast_next; result.action = act;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cfd_pkg::PH_SOF; ext_kind <= '0; flex <= 1'b0; base_id <= '0;
      shift <= '0; fcnt <= '0; scnt <= '0; hist <= '0; hcnt <= '0; dlen <= '0;
      bytes <= '0; crc <= '0; raw <= '0; raw_bits <= '0; raw_start <= '0;
      fstart <= '0; held_v <= 1'b0; held_s <= '0; held_e <= '0; remote <= 1'b0;
      fast <= 1'b0;
    end else if (bit_ok) begin
      phase <= phase_next; ext_kind <= ext_kind_next; flex <= flex_next;
      base_id <= base_id_next; shift <= shift_next; fcnt <= fcnt_next;
      scnt <= scnt_next; hist <= hist_next; hcnt <= hcnt_next; dlen <= dlen_next;
      bytes <= bytes_next; crc <= crc_next; raw <= raw_next;
      raw_bits <= raw_bits_next; raw_start <= raw_start_next; fstart <= fstart_next;
      held_v <= held_v_next; held_s <= held_s_next; held_e <= held_e_next;
      remote <= remote_next; fast <= fast_next;
    end
  end

  `CFD_ASSERT_IMP(a_idle_no_fast, clk, rst, phase == cfd_pkg::PH_SOF, !fast)
  `CFD_ASSERT_IMP(a_flex_has_kind, clk, rst, flex, ext_kind != 2'd0)
  `CFD_ASSERT_IMP(a_hcnt_range, clk, rst, 1'b1, hcnt <= 3'd5)
  `CFD_ASSERT_NEXT(a_stuff_err_idle, clk, rst,
                   bit_ok && result.n != 2'd0 && result.ev0.code == cfd_pkg::EV_STUFF_ERR,
                   phase == cfd_pkg::PH_SOF)

endmodule

### rtl/cfd_out.sv
// output sequencer: holds the results of one bit and hands them out in order
// depends on cfd_pkg
module cfd_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cfd_pkg::bit_result_t res_in,
  output logic                 busy,
  input  logic                 tready,
  output logic                 tvalid,
  output cfd_pkg::event_t      ev,
  output logic                 rate_fast,
  output logic [1:0]           action,
  output logic                 last
);

  cfd_pkg::bit_result_t held;
  logic [1:0] left, left_next;
  logic [1:0] pos, pos_next;

  assign tvalid = (left != 2'd0);
  assign last = (left == 2'd1);
  assign rate_fast = held.rate_fast;
  assign action = held.action;
  assign busy = tvalid && !(tready && last);

  always_comb begin
    case (pos)
      2'd0:    ev = held.ev0;
      2'd1:    ev = held.ev1;
      default: ev = held.ev2;
    endcase
  end

  always_comb begin
    left_next = left; pos_next = pos;
    if (tvalid && tready) begin
      left_next = left - 2'd1; pos_next = pos + 2'd1;
    end
    if (load) begin
      left_next = res_in.n; pos_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0; pos <= '0;
    end else begin
      left <= left_next; pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= res_in;
  end

endmodule

### test/can_fd_frame_bit_decoder_unit_checker.sv
`timescale 1ns / 1ps
// event checker for the can fd frame bit decoder: watches both streams, predicts the
// field events of each accepted bus bit and compares them; depends on cfd_pkg
module can_fd_frame_bit_decoder_unit_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_count,
  output int           events_pending
);

  typedef struct {
    logic [4:0]  code;
    logic [31:0] value;
    logic [5:0]  count;
    logic [31:0] start;
    logic [31:0] dur;
    logic        rate;
    logic [1:0]  act;
    logic        last;
  } field_event_t;

  field_event_t event_queue[$];
  field_event_t bit_events[3];
  int           bit_event_n;

  const logic [6:0] fd_lengths[16] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
    7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64};

  cfd_pkg::phase_t phase;
  logic [1:0]  frame_kind;
  logic        fd_frame, remote, fast;
  logic [10:0] base_id;
  logic [17:0] shift_reg;
  logic [4:0]  bit_cnt;
  logic [3:0]  stuff_cnt;
  logic [4:0]  history;
  logic [2:0]  history_cnt;
  logic [6:0]  data_len, byte_cnt;
  logic [20:0] crc;
  logic [31:0] raw_crc, raw_start, field_begin;
  logic [5:0]  raw_bits;
  logic        held_val;
  logic [31:0] held_s, held_e;

  function automatic void clear_frame();
    phase = cfd_pkg::PH_SOF; frame_kind = '0; fd_frame = 1'b0; remote = 1'b0;
    fast = 1'b0; base_id = '0; shift_reg = '0; bit_cnt = '0; stuff_cnt = '0;
    history = '0; history_cnt = '0; data_len = '0; byte_cnt = '0; crc = '0;
    raw_crc = '0; raw_bits = '0; raw_start = '0; field_begin = '0; held_val = 1'b0;
    held_s = '0; held_e = '0;
  endfunction

  function automatic void add_event(logic [4:0] c, logic [31:0] v, logic [5:0] n,
                                    logic [31:0] st, logic [31:0] du);
    if (bit_event_n < 3) begin
      bit_events[bit_event_n] = '{c, v, n, st, du, 1'b0, 2'd0, 1'b0};
      bit_event_n++;
    end
  endfunction

  function automatic logic [4:0] shift_in(logic b, logic [31:0] s);
    if (bit_cnt == 5'd0) begin
      field_begin = s;
      stuff_cnt = '0;
      crc = '0;
    end
    shift_reg = {shift_reg[16:0], b};
    bit_cnt = bit_cnt + 5'd1;
    return bit_cnt;
  endfunction

  function automatic void add_field(logic [4:0] c, logic [31:0] v, logic [31:0] e);
    add_event(c, v, 6'(bit_cnt) + 6'(stuff_cnt), field_begin, e - field_begin);
  endfunction

  function automatic bit destuffing_on();
    if (phase inside {cfd_pkg::PH_SOF, cfd_pkg::PH_ACK, cfd_pkg::PH_ACKDEL,
                      cfd_pkg::PH_EOF}) return 1'b0;
    if (fd_frame && phase inside {cfd_pkg::PH_FSB, cfd_pkg::PH_SBC, cfd_pkg::PH_CRC17,
                                  cfd_pkg::PH_CRC21, cfd_pkg::PH_CRCDEL}) return 1'b0;
    return 1'b1;
  endfunction

  // one bus bit through the frame walk; results go to the queue
  function automatic void predict_events(logic b, logic [31:0] s, logic [31:0] e);
    logic [31:0] d;
    logic [1:0]  act;
    logic [4:0]  n;
    logic [3:0]  c;
    d = e - s;
    act = cfd_pkg::ACT_NONE;
    bit_event_n = 0;
    if (phase == cfd_pkg::PH_SOF && b) return;
    if (destuffing_on() && history_cnt >= 3'd5 &&
        (history == 5'h00 || history == 5'h1F)) begin
      if ((history == 5'h00) == (b == 1'b0)) begin
        add_event(cfd_pkg::EV_STUFF_ERR, 32'd0, 6'd1, s, d);
        clear_frame();
        act = cfd_pkg::ACT_IDLE;
      end else begin
        add_event(cfd_pkg::EV_STUFF, 32'd0, 6'd1, s, d);
        if (stuff_cnt < 4'd15) stuff_cnt++;
        history = {history[3:0], b};
      end
    end else begin
      history = {history[3:0], b};
      if (history_cnt < 3'd5) history_cnt++;
      case (phase)
        cfd_pkg::PH_SOF: begin
          add_event(cfd_pkg::EV_SOF, 32'd0, 6'd1, s, d);
          phase = cfd_pkg::PH_ID1;
        end
        cfd_pkg::PH_ID1: if (shift_in(b, s) >= 5'd11) begin
          base_id = shift_reg[10:0];
          add_field(cfd_pkg::EV_ID, 32'(base_id), e);
          if (base_id[10:4] == 7'h7F) add_field(cfd_pkg::EV_ID_WARN, 32'(base_id), e);
          bit_cnt = '0;
          phase = cfd_pkg::PH_RR12;
        end
        cfd_pkg::PH_RR12: begin
          held_val = b; held_s = s; held_e = e;
          phase = cfd_pkg::PH_IDE;
        end
        cfd_pkg::PH_IDE: begin
          frame_kind = b ? 2'd2 : 2'd1;
          add_event(cfd_pkg::EV_IDE, 32'(b), 6'd1, s, d);
          phase = b ? cfd_pkg::PH_ID2 : cfd_pkg::PH_R0;
        end
        cfd_pkg::PH_ID2: if (shift_in(b, s) >= 5'd18) begin
          add_field(cfd_pkg::EV_EXT_ID, 32'(shift_reg), e);
          add_field(cfd_pkg::EV_FULL_ID, {3'd0, base_id, shift_reg}, e);
          bit_cnt = '0;
          phase = cfd_pkg::PH_RR32;
        end
        cfd_pkg::PH_RR32: begin
          add_event(cfd_pkg::EV_RTR, 32'(b), 6'd1, s, d);
          remote = b;
          phase = cfd_pkg::PH_R0;
        end
        cfd_pkg::PH_R0: begin
          fd_frame = b;
          if (frame_kind == 2'd2) begin
            if (b) add_event(cfd_pkg::EV_RES_FLEX, 32'(b), 6'd1, s, d);
            add_event(cfd_pkg::EV_SRR, 32'(held_val), 6'd1, held_s, held_e - held_s);
            phase = b ? cfd_pkg::PH_R1 : cfd_pkg::PH_R1EXT;
          end else if (b) begin
            add_event(cfd_pkg::EV_RES_FLEX, 32'(b), 6'd1, s, d);
            add_event(cfd_pkg::EV_SRR, 32'(held_val), 6'd1, held_s, held_e - held_s);
            phase = cfd_pkg::PH_R1;
          end else begin
            add_event(cfd_pkg::EV_RTR, 32'(held_val), 6'd1, held_s, held_e - held_s);
            remote = held_val;
            phase = cfd_pkg::PH_DLC;
          end
          add_event(cfd_pkg::EV_RES, 32'(b), 6'd1, s, d);
        end
        cfd_pkg::PH_R1EXT: begin
          add_event(cfd_pkg::EV_RES, 32'(b), 6'd1, s, d);
          phase = cfd_pkg::PH_DLC;
        end
        cfd_pkg::PH_R1: begin
          add_event(cfd_pkg::EV_RES, 32'(b), 6'd1, s, d);
          phase = cfd_pkg::PH_BRS;
          act = cfd_pkg::ACT_RESYNC;
        end
        cfd_pkg::PH_BRS: begin
          add_event(cfd_pkg::EV_BRS, 32'(b), 6'd1, s, d);
          if (b) fast = 1'b1;
          phase = cfd_pkg::PH_ESI;
        end
        cfd_pkg::PH_ESI: begin
          add_event(cfd_pkg::EV_ESI, 32'(b), 6'd1, s, d);
          phase = cfd_pkg::PH_DLC;
        end
        cfd_pkg::PH_DLC: if (shift_in(b, s) >= 5'd4) begin
          c = shift_reg[3:0];
          if (fd_frame) begin
            data_len = fd_lengths[c];
            add_field(cfd_pkg::EV_DLC, 32'(data_len), e);
          end else begin
            data_len = remote ? 7'd0 : (c > 4'd8 ? 7'd8 : 7'(c));
            add_field(cfd_pkg::EV_DLC, 32'(c), e);
          end
          bit_cnt = '0; byte_cnt = '0; raw_crc = '0; raw_bits = '0;
          phase = data_len != 7'd0 ? cfd_pkg::PH_DATA :
                  (fd_frame ? cfd_pkg::PH_FSB : cfd_pkg::PH_CRC15);
        end
        cfd_pkg::PH_DATA: if (shift_in(b, s) >= 5'd8) begin
          add_field(cfd_pkg::EV_DATA, 32'(shift_reg[7:0]), e);
          bit_cnt = '0;
          byte_cnt++;
          if (byte_cnt >= data_len) begin
            raw_crc = '0; raw_bits = '0;
            phase = fd_frame ? cfd_pkg::PH_FSB : cfd_pkg::PH_CRC15;
          end
        end
        cfd_pkg::PH_FSB: begin
          add_event(cfd_pkg::EV_FSB, 32'(b), 6'd1, s, d);
          raw_crc = 32'(b); raw_bits = 6'd1; raw_start = s;
          phase = cfd_pkg::PH_SBC;
        end
        cfd_pkg::PH_CRC15: if (shift_in(b, s) >= 5'd15) begin
          crc = 21'(shift_reg[14:0]);
          add_field(cfd_pkg::EV_CRC15, 32'(crc), e);
          bit_cnt = '0;
          phase = cfd_pkg::PH_CRCDEL;
        end
        cfd_pkg::PH_SBC: begin
          raw_crc = {raw_crc[30:0], b};
          raw_bits++;
          if (shift_in(b, s) >= 5'd4) begin
            add_field(cfd_pkg::EV_STUFF_CNT, 32'(shift_reg[3:0]), e);
            bit_cnt = '0;
            phase = data_len <= 7'd16 ? cfd_pkg::PH_CRC17 : cfd_pkg::PH_CRC21;
          end
        end
        cfd_pkg::PH_CRC17, cfd_pkg::PH_CRC21: begin
          raw_crc = {raw_crc[30:0], b};
          raw_bits++;
          n = shift_in(b, s);
          // every fifth bit from the first is a fixed stuff bit
          if (n % 5 == 1) add_event(cfd_pkg::EV_FSB, 32'(b), 6'd1, s, d);
          else crc = {crc[19:0], b};
          if (n >= (phase == cfd_pkg::PH_CRC17 ? 5'd22 : 5'd27)) begin
            add_field(phase == cfd_pkg::PH_CRC17 ? cfd_pkg::EV_CRC17 : cfd_pkg::EV_CRC21,
                      32'(crc), e);
            add_event(cfd_pkg::EV_FD_CRC_RAW, raw_crc, raw_bits, raw_start, e - raw_start);
            bit_cnt = '0;
            phase = cfd_pkg::PH_CRCDEL;
          end
        end
        cfd_pkg::PH_CRCDEL: begin
          add_event(cfd_pkg::EV_CRC_DELIM, 32'(b), 6'd1, s, d);
          if (!b) add_event(cfd_pkg::EV_CRC_DELIM_WARN, 32'd0, 6'd1, s, d);
          if (fd_frame) fast = 1'b0;
          phase = cfd_pkg::PH_ACK;
        end
        cfd_pkg::PH_ACK: begin
          add_event(cfd_pkg::EV_ACK, 32'(b), 6'd1, s, d);
          phase = cfd_pkg::PH_ACKDEL;
        end
        cfd_pkg::PH_ACKDEL: begin
          add_event(cfd_pkg::EV_ACK_DELIM, 32'(b), 6'd1, s, d);
          if (!b) add_event(cfd_pkg::EV_ACK_DELIM_WARN, 32'd0, 6'd1, s, d);
          phase = cfd_pkg::PH_EOF;
        end
        cfd_pkg::PH_EOF: if (shift_in(b, s) >= 5'd7) begin
          add_event(cfd_pkg::EV_EOF, 32'(shift_reg[6:0]), 6'd7, field_begin,
                    e - field_begin);
          if (shift_reg[6:0] != 7'h7F)
            add_event(cfd_pkg::EV_EOF_ERR, 32'(shift_reg[6:0]), 6'd1, s, d);
          clear_frame();
          act = cfd_pkg::ACT_IDLE;
        end
        default: clear_frame();
      endcase
    end
    for (int k = 0; k < bit_event_n; k++) begin
      bit_events[k].rate = fast;
      bit_events[k].act = act;
      bit_events[k].last = (k == bit_event_n - 1);
      event_queue = {event_queue, bit_events[k]};
    end
  endfunction

  always @(posedge clk) begin
    field_event_t exp_ev;
    if (rst) begin
      clear_frame();
      event_queue.delete();
      fail_count <= 0;
      events_pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (event_queue.size() == 0) begin
          $error("event with none expected: code %0d", m_axis_tdata[4:0]);
          fail_count <= fail_count + 1;
        end else begin
          exp_ev = event_queue.pop_front();
          // tdata from bit 0: code, value, count, start, duration
          if (m_axis_tdata[4:0] !== exp_ev.code ||
              m_axis_tdata[36:5] !== exp_ev.value ||
              m_axis_tdata[42:37] !== exp_ev.count ||
              m_axis_tdata[74:43] !== exp_ev.start ||
              m_axis_tdata[106:75] !== exp_ev.dur ||
              m_axis_tuser[0] !== exp_ev.rate ||
              m_axis_tuser[2:1] !== exp_ev.act ||
              m_axis_tlast !== exp_ev.last) begin
            fail_count <= fail_count + 1;
            if (m_axis_tdata[4:0] !== exp_ev.code)
              $error("event_code exp %0d got %0d", exp_ev.code, m_axis_tdata[4:0]);
            if (m_axis_tdata[36:5] !== exp_ev.value)
              $error("field_value exp %h got %h", exp_ev.value, m_axis_tdata[36:5]);
            if (m_axis_tdata[42:37] !== exp_ev.count)
              $error("bit_count exp %0d got %0d", exp_ev.count, m_axis_tdata[42:37]);
            if (m_axis_tdata[74:43] !== exp_ev.start)
              $error("start_sample exp %h got %h", exp_ev.start, m_axis_tdata[74:43]);
            if (m_axis_tdata[106:75] !== exp_ev.dur)
              $error("duration_samples exp %h got %h", exp_ev.dur, m_axis_tdata[106:75]);
            if (m_axis_tuser[0] !== exp_ev.rate)
              $error("rate_fast exp %0d got %0d", exp_ev.rate, m_axis_tuser[0]);
            if (m_axis_tuser[2:1] !== exp_ev.act)
              $error("sampler_action exp %0d got %0d", exp_ev.act, m_axis_tuser[2:1]);
            if (m_axis_tlast !== exp_ev.last)
              $error("last_of_bit exp %0d got %0d", exp_ev.last, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_events(s_axis_tdata[0], s_axis_tdata[32:1], s_axis_tdata[64:33]);
      events_pending <= event_queue.size();
    end
  end

endmodule

### test/can_fd_frame_bit_decoder_unit_test.sv
`timescale 1ns / 1ps
// top of the can fd frame bit decoder testbench: builds stuffed bus frames, drives them
// into the decoder and gives the verdict; depends on cfd_pkg and the event checker
module can_fd_frame_bit_decoder_unit_test;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;  // bit_value, bit_start, bit_end
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [111:0] m_axis_tdata;       // event_code, field_value, bit_count, start, duration
  logic [2:0]   m_axis_tuser;       // rate_fast, sampler_action
  logic         m_axis_tlast;
  int           fail_count, events_pending;

  // sender side bookkeeping
  logic [31:0] sample_pos;
  logic [4:0]  line_history;   // last five driven levels, for stuff insertion
  int          line_run;
  bit          idling_on = 1;
  bit          hold_request = 0;
  bit          corrupt_on = 0;

  always #2 clk = ~clk;

  can_fd_frame_bit_decoder_unit DUT (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  can_fd_frame_bit_decoder_unit_checker checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count, .events_pending
  );

  // one transaction on the bit stream, with an occasional random gap before it
  task automatic drive_bit(input logic b);
    logic [31:0] width;
    int gap;
    width = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, 40);
    gap = (idling_on && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 15)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, sample_pos + width, sample_pos, b};
    do @(posedge clk); while (!s_axis_tready);
    sample_pos = sample_pos + width;
  endtask

  task automatic line_level(input logic b);
    line_run = (line_run > 0 && b == line_history[0]) ? line_run + 1 : 1;
    line_history = {line_history[3:0], b};
    drive_bit(b);
  endtask

  // logical frame bit; inside the stuffed region an opposite bit follows five equal ones
  task automatic frame_bit(input logic b, input bit stuffed);
    if (stuffed && line_run >= 5) line_level(~line_history[0]);
    if (corrupt_on && $urandom_range(0, 199) == 0) b = ~b;
    line_level(b);
  endtask

  task automatic frame_field(input logic [31:0] v, input int n, input bit stuffed);
    for (int i = n - 1; i >= 0; i--) frame_bit(v[i], stuffed);
  endtask

  task automatic send_frame(input bit ext, input bit fd, input bit brs, input bit rtr,
                            input logic [28:0] fid, input logic [3:0] dlc,
                            input bit bad_tail);
    int bytes;
    logic [6:0] fd_bytes[16];
    fd_bytes = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
                 7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64};
    line_run = 0;
    frame_bit(1'b0, 1'b0);                          // start of frame
    frame_field(32'(fid[28:18]), 11, 1'b1);
    frame_bit(ext ? 1'b1 : rtr, 1'b1);              // rtr or srr
    frame_bit(ext, 1'b1);                           // ide
    if (ext) begin
      frame_field(32'(fid[17:0]), 18, 1'b1);
      frame_bit(fd ? 1'b0 : rtr, 1'b1);
    end
    frame_bit(fd, 1'b1);                            // fdf / r0
    if (fd) begin
      frame_bit(1'b0, 1'b1);
      frame_bit(brs, 1'b1);
      frame_bit(1'($urandom_range(0, 1)), 1'b1);    // esi
    end else if (ext) begin
      frame_bit(1'b0, 1'b1);
    end
    frame_field(32'(dlc), 4, 1'b1);
    bytes = fd ? int'(fd_bytes[dlc]) : (rtr ? 0 : (dlc > 4'd8 ? 8 : int'(dlc)));
    repeat (bytes) frame_field($urandom, 8, 1'b1);
    if (fd) begin
      frame_bit(1'($urandom_range(0, 1)), 1'b0);    // fixed stuff bit
      frame_field($urandom, 4, 1'b0);
      frame_field($urandom, bytes <= 16 ? 22 : 27, 1'b0);
      frame_bit(bad_tail ? 1'($urandom_range(0, 1)) : 1'b1, 1'b0);
    end else begin
      frame_field($urandom, 15, 1'b1);
      frame_bit(bad_tail ? 1'($urandom_range(0, 1)) : 1'b1, 1'b1);
    end
    frame_bit(1'($urandom_range(0, 1)), 1'b0);      // ack slot
    frame_bit(bad_tail ? 1'($urandom_range(0, 1)) : 1'b1, 1'b0);
    frame_field(bad_tail ? $urandom : 32'h7F, 7, 1'b0);
    repeat ($urandom_range(0, 3)) frame_bit(1'b1, 1'b0);  // bus idle, ignored
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_axis_tready <= 0;
        repeat (60) @(negedge clk);
        hold_request = 0;
        m_axis_tready <= 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        m_axis_tready <= 1;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sample_pos = 32'hFFFF_FF00;  // wraps early in the directed part
    line_history = 0;
    line_run = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extended remote frame with the top seven base id bits set, for the id warning
    send_frame(1'b1, 1'b0, 1'b0, 1'b1, 29'h1FC0_0000, 4'd15, 1'b0);

    // sender waits for every expected event
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (events_pending != 0) @(negedge clk);

    // long receiver hold while the sender keeps offering: fd frame with rate
    // switch, occasional corrupted bits and a possibly broken tail
    hold_request = 1;
    corrupt_on = 1;
    send_frame(1'b0, 1'b1, 1'b1, 1'b0, 29'h0123_4567, 4'd0, 1'b1);
    corrupt_on = 0;

    // last part without idling: classic data frame
    idling_on = 0;
    send_frame(1'b0, 1'b0, 1'b0, 1'b0, 29'h0AAA_AAAA, 4'd1, 1'b0);

    @(negedge clk);
    s_axis_tvalid <= 0;
    while (events_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
